// ===== src/first_order_lowpass_filter_assert.svh =====
// ----------------------------------------------------------------------------
// first_order_lowpass_filter_assert.svh
// Assertion macros used by the low-pass filter checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_ORDER_LOWPASS_FILTER_ASSERT_SVH
`define FIRST_ORDER_LOWPASS_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lowpass filter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lowpass filter check failed");

`endif

// ===== src/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// Types and constants shared by the first-order low-pass filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpf_pkg;

    // Field and register widths.
    localparam int DATA_W    = 32;
    localparam int REG_W     = 12;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int OPND_W    = 33;
    localparam int WIDE_W    = 64;
    localparam int DIVISOR_W = 26;
    localparam int COEF_W    = 27;
    localparam int STEP_W    = 6;

    // Gain scale factor.
    localparam int SCALE = 1000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TIME_CONSTANT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 8'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_NUM,
        S_FB,
        S_ACC,
        S_START,
        S_DIV
    } state_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== src/lpf_mul.sv =====
// ----------------------------------------------------------------------------
// lpf_mul
// Shared signed multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_mul (
    input  wire logic                                 clk,
    input  wire logic signed [lpf_pkg::OPND_W-1:0]   a,
    input  wire logic signed [lpf_pkg::OPND_W-1:0]   b,
    output logic signed      [lpf_pkg::WIDE_W-1:0]   product
);

    logic signed [2*lpf_pkg::OPND_W-1:0] prod_full;

    // Full-width signed product; every use here fits in 64 bits.
    assign prod_full = a * b;

    // Product register.
    always_ff @(posedge clk)
    begin
        product <= prod_full[lpf_pkg::WIDE_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/lpf_div.sv =====
// ----------------------------------------------------------------------------
// lpf_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [lpf_pkg::WIDE_W-1:0]       dividend,
    input  wire logic [lpf_pkg::DIVISOR_W-1:0]    divisor,
    output logic      [lpf_pkg::WIDE_W-1:0]       quotient,
    output lpf_pkg::div_status_t                   status
);

    logic [lpf_pkg::WIDE_W-1:0]    quo_reg, quo_next;
    logic [lpf_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [lpf_pkg::DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [lpf_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lpf_pkg::DIVISOR_W+1:0] trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {1'b0, rem_reg, quo_reg[lpf_pkg::WIDE_W-1]} - {2'b00, dvs_reg};

    // Next-state logic for one division step.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!trial[lpf_pkg::DIVISOR_W+1])
            begin
                rem_next = trial[lpf_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[lpf_pkg::WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[lpf_pkg::DIVISOR_W-2:0], quo_reg[lpf_pkg::WIDE_W-1]};
                quo_next = {quo_reg[lpf_pkg::WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ===== src/first_order_lowpass_filter.sv =====
// An accepted sample steps through GAIN, NUM, FB, ACC, START and DIV to the output register.
// in_ready is high only in IDLE, so no new sample is taken until the 64-step radix-2 divider is done.
// A finished item waits in the output register while the next sample is taken.
// Reset: time_constant 0, sample_rate 1, both history registers zero, no item held.
// Configuration writes are taken in any cycle; a write to a real register clears the filter history.
// ----------------------------------------------------------------------------
// first_order_lowpass_filter
// Bilinear first-order low-pass filter with a shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module first_order_lowpass_filter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [lpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [lpf_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [lpf_pkg::DATA_W-1:0]     sample,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed      [lpf_pkg::DATA_W-1:0]     filtered
);

    localparam int DW = lpf_pkg::DATA_W;
    localparam int OW = lpf_pkg::OPND_W;
    localparam int WW = lpf_pkg::WIDE_W;

    lpf_pkg::state_t state_reg, state_next;

    logic        [lpf_pkg::REG_W-1:0]     tc_reg, tc_next;
    logic        [lpf_pkg::REG_W-1:0]     sr_reg, sr_next;
    logic signed [DW-1:0]                 xp_reg, xp_next;
    logic signed [DW-1:0]                 yp_reg, yp_next;
    logic signed [DW-1:0]                 x_reg, x_next;
    logic        [lpf_pkg::DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic signed [lpf_pkg::COEF_W-1:0]    coef_reg, coef_next;
    logic signed [WW-1:0]                 acc_reg, acc_next;
    logic                                 neg_reg, neg_next;
    logic signed [DW-1:0]                 out_reg, out_next;
    logic                                 out_valid_reg, out_valid_next;

    logic signed [OW-1:0]          mul_a, mul_b;
    logic signed [WW-1:0]          mul_p;
    logic                          div_start;
    logic        [WW-1:0]          div_dividend;
    logic        [WW-1:0]          div_quo;
    lpf_pkg::div_status_t          div_status;
    logic signed [DW-1:0]          y_sat;
    logic                          sat_hi, sat_lo;

    // Shared multiplier.
    lpf_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // Magnitude of the numerator goes to the divider; the sign is applied after.
    assign div_dividend = acc_reg[WW-1] ? WW'(-acc_reg) : WW'(acc_reg);

    // Shared divider.
    lpf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dvs_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    // Apply the sign and saturate the quotient to 32 bits.
    always_comb
    begin
        sat_hi = !neg_reg && (|div_quo[WW-1:DW-1]);
        sat_lo = neg_reg && ((|div_quo[WW-1:DW]) ||
                             (div_quo[DW-1] && (|div_quo[DW-2:0])));
        if (sat_hi)
            y_sat = {1'b0, {(DW-1){1'b1}}};
        else if (sat_lo)
            y_sat = {1'b1, {(DW-1){1'b0}}};
        else if (neg_reg)
            y_sat = -$signed(div_quo[DW-1:0]);
        else
            y_sat = $signed(div_quo[DW-1:0]);
    end

    // Sequencer: next state, operand selection and register updates.
    always_comb
    begin
        state_next     = state_reg;
        tc_next        = tc_reg;
        sr_next        = sr_reg;
        xp_next        = xp_reg;
        yp_next        = yp_reg;
        x_next         = x_reg;
        dvs_next       = dvs_reg;
        coef_next      = coef_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;

        // The output register empties when its item is taken.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            lpf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample;
                    state_next = lpf_pkg::S_GAIN;
                end
            end
            lpf_pkg::S_GAIN:
            begin
                // time_constant * sample_rate
                mul_a      = OW'(tc_reg);
                mul_b      = OW'(sr_reg);
                state_next = lpf_pkg::S_NUM;
            end
            lpf_pkg::S_NUM:
            begin
                // Divisor and feedback coefficient from gain = 2 * tc * sr.
                dvs_next  = lpf_pkg::DIVISOR_W'(lpf_pkg::SCALE) +
                            {mul_p[lpf_pkg::DIVISOR_W-2:0], 1'b0};
                coef_next = lpf_pkg::COEF_W'(lpf_pkg::SCALE) -
                            $signed({1'b0, mul_p[lpf_pkg::DIVISOR_W-2:0], 1'b0});
                // 1000 * (x + last_sample)
                mul_a      = OW'(x_reg) + OW'(xp_reg);
                mul_b      = OW'(lpf_pkg::SCALE);
                state_next = lpf_pkg::S_FB;
            end
            lpf_pkg::S_FB:
            begin
                acc_next = mul_p;
                // (1000 - gain) * last_filtered
                mul_a      = OW'(coef_reg);
                mul_b      = OW'(yp_reg);
                state_next = lpf_pkg::S_ACC;
            end
            lpf_pkg::S_ACC:
            begin
                acc_next   = acc_reg - mul_p;
                state_next = lpf_pkg::S_START;
            end
            lpf_pkg::S_START:
            begin
                neg_next   = acc_reg[WW-1];
                div_start  = 1'b1;
                state_next = lpf_pkg::S_DIV;
            end
            lpf_pkg::S_DIV:
            begin
                // Deliver once the divider is done and the output register is free.
                if (div_status.done && (!out_valid_reg || out_ready))
                begin
                    out_next       = y_sat;
                    out_valid_next = 1'b1;
                    xp_next        = x_reg;
                    yp_next        = y_sat;
                    state_next     = lpf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpf_pkg::S_IDLE;
            end
        endcase

        // Configuration write: update the register and clear the history.
        if (cfg_valid)
        begin
            if (cfg_index == lpf_pkg::REG_TIME_CONSTANT)
            begin
                tc_next = cfg_data[lpf_pkg::REG_W-1:0];
                xp_next = '0;
                yp_next = '0;
            end
            else if (cfg_index == lpf_pkg::REG_SAMPLE_RATE)
            begin
                sr_next = cfg_data[lpf_pkg::REG_W-1:0];
                xp_next = '0;
                yp_next = '0;
            end
        end
    end

    // Control state, configuration and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpf_pkg::S_IDLE;
            tc_reg        <= '0;
            sr_reg        <= lpf_pkg::REG_W'(1);
            xp_reg        <= '0;
            yp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tc_reg        <= tc_next;
            sr_reg        <= sr_next;
            xp_reg        <= xp_next;
            yp_reg        <= yp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        dvs_reg  <= dvs_next;
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == lpf_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign filtered  = out_reg;

endmodule

`default_nettype wire

// ===== src/first_order_lowpass_filter_check.sv =====
// ----------------------------------------------------------------------------
// first_order_lowpass_filter_check
// Port-level checks for the low-pass filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_order_lowpass_filter_assert.svh"

module first_order_lowpass_filter_check (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   in_valid,
    input wire logic                                   in_ready,
    input wire logic signed [lpf_pkg::DATA_W-1:0]     sample,
    input wire logic                                   out_valid,
    input wire logic                                   out_ready,
    input wire logic signed [lpf_pkg::DATA_W-1:0]     filtered
);

    // An accepted sample keeps the block busy for the following cycle.
    `LPF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // Returning to idle always leaves a finished item on the output.
    `LPF_ASSERT_NOW(a_result_on_idle, clk, rst_n, $rose(in_ready), out_valid)

    // A stalled output item holds its value.
    `LPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(filtered))

    // A waiting input item holds its value.
    `LPF_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
                     in_valid && $stable(sample))

endmodule

bind first_order_lowpass_filter first_order_lowpass_filter_check u_check (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-order low-pass filter. A bit-true model
// in the bench predicts every filtered item from the samples it accepts and
// the registers it writes. A checker compares each item that leaves the
// block with the oldest prediction. Directed sequences cover the register
// reset values, the register writes and the saturation limits. Random
// phases follow, each of which may write a new filter setting, under random sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 700;
    localparam int DRAIN_CYCLES  = 100;
    localparam int QUIET_LIMIT   = 4000;

    // An index that no register answers to.
    localparam logic [lpf_pkg::CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 8'hA5;

    localparam logic signed [lpf_pkg::DATA_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
    localparam logic signed [lpf_pkg::DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam longint FILT_MAX = 64'sd2147483647;
    localparam longint FILT_MIN = -64'sd2147483648;

    typedef enum {
        READY_ALWAYS,
        READY_CHOPPY,
        READY_LONG_STALLS
    } ready_mode_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [lpf_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [lpf_pkg::CFG_DAT_W-1:0]        cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [lpf_pkg::DATA_W-1:0]    sample = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [lpf_pkg::DATA_W-1:0]    filtered;

    // Filter model state: registers and history.
    logic [lpf_pkg::REG_W-1:0]            model_tau = '0;
    logic [lpf_pkg::REG_W-1:0]            model_rate = 1;
    logic signed [lpf_pkg::DATA_W-1:0]    model_last_sample = '0;
    logic signed [lpf_pkg::DATA_W-1:0]    model_last_filtered = '0;

    logic signed [lpf_pkg::DATA_W-1:0]    expected_filtered[$];
    logic signed [lpf_pkg::DATA_W-1:0]    want_filtered;
    int unsigned                          errors = 0;
    int unsigned                          burst_left = 0;
    int unsigned                          quiet_cycles = 0;
    int unsigned                          stall_left = 0;
    int unsigned                          mode_left = 0;
    ready_mode_t                          ready_mode = READY_ALWAYS;

    first_order_lowpass_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

    always #(CLK_HALF) clk = ~clk;

    // Advance the filter model by one sample and return the expected output.
    function automatic logic signed [lpf_pkg::DATA_W-1:0] predict_filtered(
        input logic signed [lpf_pkg::DATA_W-1:0] x
    );
        longint gain;
        longint num;
        longint quot;
        logic signed [lpf_pkg::DATA_W-1:0] y;
        gain = 2 * longint'(model_tau) * longint'(model_rate);
        num  = longint'(lpf_pkg::SCALE) * longint'(x)
             + longint'(lpf_pkg::SCALE) * longint'(model_last_sample)
             - (longint'(lpf_pkg::SCALE) - gain) * longint'(model_last_filtered);
        quot = num / (longint'(lpf_pkg::SCALE) + gain);
        if (quot > FILT_MAX)
            quot = FILT_MAX;
        else if (quot < FILT_MIN)
            quot = FILT_MIN;
        y = quot[lpf_pkg::DATA_W-1:0];
        model_last_sample   = x;
        model_last_filtered = y;
        return y;
    endfunction

    // Send one sample, with a random gap at the end of each burst.
    task automatic send_sample(input logic signed [lpf_pkg::DATA_W-1:0] value);
        int unsigned gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        expected_filtered.push_back(predict_filtered(value));
    endtask

    // Write one register once the filter has delivered everything.
    task automatic write_register(
        input logic [lpf_pkg::CFG_IDX_W-1:0] index,
        input logic [lpf_pkg::CFG_DAT_W-1:0] data
    );
        in_valid   <= 1'b0;
        burst_left = 0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // A write to a real register restarts the filter from zero history.
        if (index == lpf_pkg::REG_TIME_CONSTANT)
        begin
            model_tau           = data[lpf_pkg::REG_W-1:0];
            model_last_sample   = '0;
            model_last_filtered = '0;
        end
        else if (index == lpf_pkg::REG_SAMPLE_RATE)
        begin
            model_rate          = data[lpf_pkg::REG_W-1:0];
            model_last_sample   = '0;
            model_last_filtered = '0;
        end
    endtask

    function automatic logic signed [lpf_pkg::DATA_W-1:0] random_sample(
        input logic signed [lpf_pkg::DATA_W-1:0] last
    );
        logic signed [lpf_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = SAMPLE_MAX;
                    1: v = SAMPLE_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2:
            begin
                v = $urandom_range(0, 2000);
                v = v - 1000;
            end
            3: v = last;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Register reset values give zero gain: the output follows x + x_prev - y_prev.
    task automatic test_reset_defaults();
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('1);
        send_sample(32'sd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
    endtask

    // Largest gain, zero sample rate, unused index and both saturation limits.
    task automatic test_register_writes();
        write_register(lpf_pkg::REG_TIME_CONSTANT, 32'd4095);
        write_register(lpf_pkg::REG_SAMPLE_RATE, 32'd4095);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        // Only the low bits of the data count, so this sets the rate to zero.
        write_register(lpf_pkg::REG_SAMPLE_RATE, 32'hFFFF_F000);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        // A write to an unused index must leave the history alone.
        write_register(REG_OUT_OF_RANGE, 32'hFFFF_FFFF);
        send_sample(32'sd12345);
        // Gain of two: two full-scale negative samples drive the output past the
        // negative limit, and two positive ones then past the positive limit.
        write_register(lpf_pkg::REG_TIME_CONSTANT, 32'hABCD_E001);
        write_register(lpf_pkg::REG_SAMPLE_RATE, 32'h5432_1001);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
    endtask

    // Random phases, each of which may write a new filter setting before a run of samples.
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned tau_val;
        int unsigned rate_val;
        logic [lpf_pkg::CFG_DAT_W-1:0] data;
        logic signed [lpf_pkg::DATA_W-1:0] last;
        sent = 0;
        last = '0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    tau_val  = 4095;
                    rate_val = 4095;
                end
                1:
                begin
                    tau_val  = 0;
                    rate_val = $urandom_range(0, 4095);
                end
                2:
                begin
                    tau_val  = $urandom_range(0, 4095);
                    rate_val = 0;
                end
                3:
                begin
                    tau_val  = $urandom_range(0, 31);
                    rate_val = $urandom_range(1, 15);
                end
                default:
                begin
                    tau_val  = $urandom_range(0, 4095);
                    rate_val = $urandom_range(1, 4095);
                end
            endcase
            if ($urandom_range(0, 3) != 1)
            begin
                data = $urandom;
                data[lpf_pkg::REG_W-1:0] = tau_val[lpf_pkg::REG_W-1:0];
                write_register(lpf_pkg::REG_TIME_CONSTANT, data);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                data = $urandom;
                data[lpf_pkg::REG_W-1:0] = rate_val[lpf_pkg::REG_W-1:0];
                write_register(lpf_pkg::REG_SAMPLE_RATE, data);
            end
            if ($urandom_range(0, 7) == 0)
                write_register(lpf_pkg::CFG_IDX_W'($urandom_range(
                                   int'(lpf_pkg::REG_SAMPLE_RATE) + 1, 255)),
                               $urandom);
            phase_len = $urandom_range(10, 60);
            repeat (phase_len)
            begin
                last = random_sample(last);
                send_sample(last);
                sent++;
            end
        end
    endtask

    // Receiver: picks a new stall pattern whenever its mode counter runs out.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(100, 400);
        end
        else
        begin
            mode_left--;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            case (ready_mode)
                READY_CHOPPY:
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 3);
                READY_LONG_STALLS:
                    if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(5, 40);
                default: ;
            endcase
        end
    end

    // Compare each filtered item with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_filtered.size() == 0)
            begin
                $display("%0t: filtered item %0d arrived with none expected",
                         $time, filtered);
                errors++;
            end
            else
            begin
                want_filtered = expected_filtered.pop_front();
                if (filtered !== want_filtered)
                begin
                    $display("%0t: filtered mismatch, expected %0d, got %0d",
                             $time, want_filtered, filtered);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run if no item moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_writes();
        test_random_traffic();

        // Let the last items drain before judging the run.
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
